@@ rtl/cartesian_to_spherical_defines.svh @@
// Assertion macros for the cartesian to spherical converter.
// Needs clk and rst in the scope where a macro is used.
`ifndef CARTESIAN_TO_SPHERICAL_DEFINES_SVH
`define CARTESIAN_TO_SPHERICAL_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Check cons in the same cycle as ante.
`define CS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("c2s: assertion failed");
// Check cons in the cycle after ante.
`define CS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("c2s: assertion failed");
`else
`define CS_ASSERT_NOW(label, ante, cons)
`define CS_ASSERT_NEXT(label, ante, cons)
`endif
`endif

@@ rtl/c2s_pkg.sv @@
// Shared types, widths and constants for the cartesian to spherical converter.
// No dependencies.
package c2s_pkg;

  localparam int COORD_WIDTH       = 16;
  localparam int CORDIC_STAGES_DEF = 16;
  localparam int TABLE_LEN         = 24;

  localparam int ANGLE_W    = 16;
  localparam int RANGE_W    = 16;
  localparam int FRAC_SHIFT = 16;
  // vector width: coordinate scaled by 2^16 plus headroom for two CORDIC gains
  localparam int DATA_W     = COORD_WIDTH + 20;
  localparam int ACC_W      = 34;
  localparam int GAIN_W     = 18;
  localparam int DEG_W      = 32;
  localparam int SQ_PAIRS   = COORD_WIDTH + 1;
  localparam int SQ_N_W     = 2 * SQ_PAIRS;
  localparam int SQ_REM_W   = SQ_PAIRS + 2;

  localparam logic signed [ACC_W-1:0]   HALF_PI_Q30     = ACC_W'(1686629713);
  localparam logic signed [GAIN_W-1:0]  GAIN_Q16        = GAIN_W'(107922);
  localparam logic signed [DEG_W-1:0]   DEG_PER_RAD_Q24 = DEG_W'(961263669);
  localparam logic signed [ANGLE_W-1:0] RAD_LIMIT       = ANGLE_W'(25736);
  localparam logic signed [ANGLE_W-1:0] DEG_LIMIT       = ANGLE_W'(11520);
  localparam logic [RANGE_W-1:0]        RANGE_MAX       = '1;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] x_coord;
    logic signed [COORD_WIDTH-1:0] y_coord;
    logic signed [COORD_WIDTH-1:0] z_coord;
  } c2s_point_t;

  typedef struct packed {
    logic signed [ANGLE_W-1:0] azimuth;
    logic signed [ANGLE_W-1:0] elevation;
    logic [RANGE_W-1:0]        range;
    logic                      azimuth_valid;
    logic                      elevation_valid;
  } c2s_result_t;

  // Everything one point carries along the cell chain
  typedef struct packed {
    logic                     az_ok;
    logic                     el_ok;
    logic signed [DATA_W-1:0] vx;
    logic signed [DATA_W-1:0] vy;
    logic signed [DATA_W-1:0] ez;
    logic signed [ACC_W-1:0]  az_acc;
    logic signed [ACC_W-1:0]  el_acc;
    logic [SQ_N_W-1:0]        sq_n;
    logic [SQ_REM_W-1:0]      sq_rem;
    logic [SQ_PAIRS-1:0]      sq_root;
  } c2s_cell_t;

  // atan(2^-i) in radians Q30, truncated
  function automatic logic signed [ACC_W-1:0] atan_q30(input int idx);
    case (idx)
      0:  return ACC_W'(32'h3243F6A8);
      1:  return ACC_W'(32'h1DAC6705);
      2:  return ACC_W'(32'h0FADBAFC);
      3:  return ACC_W'(32'h07F56EA6);
      4:  return ACC_W'(32'h03FEAB76);
      5:  return ACC_W'(32'h01FFD55B);
      6:  return ACC_W'(32'h00FFFAAA);
      7:  return ACC_W'(32'h007FFF55);
      8:  return ACC_W'(32'h003FFFEA);
      9:  return ACC_W'(32'h001FFFFD);
      10: return ACC_W'(32'h000FFFFF);
      11: return ACC_W'(32'h0007FFFF);
      12: return ACC_W'(32'h0003FFFF);
      13: return ACC_W'(32'h0001FFFF);
      14: return ACC_W'(32'h0000FFFF);
      15: return ACC_W'(32'h00007FFF);
      16: return ACC_W'(32'h00003FFF);
      17: return ACC_W'(32'h00001FFF);
      18: return ACC_W'(32'h00000FFF);
      19: return ACC_W'(32'h000007FF);
      20: return ACC_W'(32'h000003FF);
      21: return ACC_W'(32'h000001FF);
      22: return ACC_W'(32'h000000FF);
      23: return ACC_W'(32'h0000007F);
      default: return '0;
    endcase
  endfunction

endpackage

@@ rtl/c2s_prep.sv @@
// Entry cell: scales the point, turns it into the right half plane, forms x^2+y^2+z^2.
// Depends on c2s_pkg.
module c2s_prep import c2s_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  c2s_point_t in_point,
  input  logic       down_hold,
  output logic       hold,
  output logic       out_valid,
  output c2s_cell_t  out_data
);

  logic                                  valid;
  c2s_cell_t                             data;
  c2s_cell_t                             data_next;
  logic signed [COORD_WIDTH-1:0]         x;
  logic signed [COORD_WIDTH-1:0]         y;
  logic signed [COORD_WIDTH-1:0]         z;
  logic signed [DATA_W-1:0]              cx;
  logic signed [DATA_W-1:0]              cy;
  logic signed [2*COORD_WIDTH-1:0]       sq_x;
  logic signed [2*COORD_WIDTH-1:0]       sq_y;
  logic signed [2*COORD_WIDTH-1:0]       sq_z;
  logic signed [COORD_WIDTH+GAIN_W-1:0]  ez_prod;

  assign hold = valid & down_hold;

  always_comb begin
    x = in_point.x_coord;
    y = in_point.y_coord;
    z = in_point.z_coord;
    cx = DATA_W'(x) <<< FRAC_SHIFT;
    cy = DATA_W'(y) <<< FRAC_SHIFT;
    sq_x = x * x;
    sq_y = y * y;
    sq_z = z * z;
    ez_prod = z * GAIN_Q16;

    data_next.az_ok = (x != '0) || (y != '0);
    data_next.el_ok = (x != '0) || (y != '0) || (z != '0);
    data_next.ez = DATA_W'(ez_prod);
    data_next.el_acc = '0;
    data_next.sq_n = SQ_N_W'($unsigned(sq_x)) + SQ_N_W'($unsigned(sq_y))
                   + SQ_N_W'($unsigned(sq_z));
    data_next.sq_rem = '0;
    data_next.sq_root = '0;
    // left half plane: rotate by a quarter turn first
    if (x[COORD_WIDTH-1]) begin
      if (!y[COORD_WIDTH-1]) begin
        data_next.vx = cy;
        data_next.vy = -cx;
        data_next.az_acc = HALF_PI_Q30;
      end else begin
        data_next.vx = -cy;
        data_next.vy = cx;
        data_next.az_acc = -HALF_PI_Q30;
      end
    end else begin
      data_next.vx = cx;
      data_next.vy = cy;
      data_next.az_acc = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (!hold) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!hold && in_valid) begin
      data <= data_next;
    end
  end

  assign out_valid = valid;
  assign out_data  = data;

endmodule

@@ rtl/c2s_cell.sv @@
// One cell of the chain: a CORDIC micro-rotation and one square-root digit, each where IDX selects it.
// Depends on c2s_pkg.
module c2s_cell import c2s_pkg::*; #(
  parameter int IDX        = 0,
  parameter int STAGES_RUN = CORDIC_STAGES_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  c2s_cell_t in_data,
  input  logic      down_hold,
  output logic      hold,
  output logic      out_valid,
  output c2s_cell_t out_data
);

  localparam bit IS_AZ    = (IDX < STAGES_RUN);
  localparam bit IS_EL    = (IDX >= STAGES_RUN) && (IDX < 2 * STAGES_RUN);
  localparam bit FIRST_EL = (IDX == STAGES_RUN);
  localparam bit SQ_ON    = (IDX < SQ_PAIRS);
  localparam int SHIFT    = IS_AZ ? IDX : (IS_EL ? IDX - STAGES_RUN : 0);
  localparam logic signed [ACC_W-1:0] STEP = atan_q30(SHIFT);

  logic                     valid;
  c2s_cell_t                data;
  c2s_cell_t                data_next;
  logic signed [DATA_W-1:0] x_in;
  logic signed [DATA_W-1:0] y_in;
  logic signed [DATA_W-1:0] dx;
  logic signed [DATA_W-1:0] dy;
  logic signed [DATA_W-1:0] x_rot;
  logic signed [DATA_W-1:0] y_rot;
  logic signed [ACC_W-1:0]  step_signed;
  logic [SQ_REM_W-1:0]      rem_sh;
  logic [SQ_REM_W-1:0]      trial;
  logic                     sq_take;

  assign hold = valid & down_hold;

  always_comb begin
    data_next = in_data;
    x_in = in_data.vx;
    // elevation pass starts from (planar length, scaled z)
    y_in = FIRST_EL ? in_data.ez : in_data.vy;
    dx = y_in >>> SHIFT;
    dy = x_in >>> SHIFT;
    if (!y_in[DATA_W-1]) begin
      x_rot = x_in + dx;
      y_rot = y_in - dy;
      step_signed = STEP;
    end else begin
      x_rot = x_in - dx;
      y_rot = y_in + dy;
      step_signed = -STEP;
    end
    if (IS_AZ) begin
      data_next.vx = x_rot;
      data_next.vy = y_rot;
      data_next.az_acc = in_data.az_acc + step_signed;
    end else if (IS_EL) begin
      data_next.vx = x_rot;
      data_next.vy = y_rot;
      data_next.el_acc = in_data.el_acc + step_signed;
    end

    // restoring square root, one result bit per cell while IDX < SQ_PAIRS
    rem_sh = {in_data.sq_rem[SQ_REM_W-3:0], in_data.sq_n[SQ_N_W-1 -: 2]};
    trial = {in_data.sq_root, 2'b01};
    sq_take = (rem_sh >= trial);
    if (SQ_ON) begin
      data_next.sq_rem = sq_take ? (rem_sh - trial) : rem_sh;
      data_next.sq_root = {in_data.sq_root[SQ_PAIRS-2:0], sq_take};
      data_next.sq_n = in_data.sq_n << 2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (!hold) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!hold && in_valid) begin
      data <= data_next;
    end
  end

  assign out_valid = valid;
  assign out_data  = data;

endmodule

@@ rtl/c2s_format.sv @@
// Output cells: angle scaling to radians or degrees, range rounding, result register.
// Depends on c2s_pkg.
module c2s_format import c2s_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        angle_in_degrees,
  input  logic        in_valid,
  input  c2s_cell_t   in_data,
  input  logic        down_hold,
  output logic        hold,
  output logic        out_valid,
  output c2s_result_t out_result
);

  localparam int HI_W      = ACC_W - FRAC_SHIFT;
  localparam int PH_W      = HI_W + DEG_W;
  localparam int PL_W      = FRAC_SHIFT + 1 + DEG_W;
  localparam int PROD_W    = ACC_W + DEG_W + 2;
  localparam int RAD_SHIFT = FRAC_SHIFT + 1;
  localparam int DEG_SHIFT = 48;
  localparam logic signed [ACC_W:0]    RAD_BIAS = (ACC_W+1)'(1) <<< FRAC_SHIFT;
  localparam logic signed [PROD_W-1:0] DEG_BIAS = PROD_W'(1) <<< (DEG_SHIFT - 1);

  typedef struct packed {
    logic                      az_ok;
    logic                      el_ok;
    logic signed [ANGLE_W-1:0] az_rad;
    logic signed [ANGLE_W-1:0] el_rad;
    logic signed [PH_W-1:0]    az_ph;
    logic signed [PL_W-1:0]    az_pl;
    logic signed [PH_W-1:0]    el_ph;
    logic signed [PL_W-1:0]    el_pl;
    logic [RANGE_W-1:0]        range;
  } fmt_stage_t;

  function automatic logic signed [ANGLE_W-1:0] sat_angle(
    input logic signed [PROD_W-1:0]  v,
    input logic signed [ANGLE_W-1:0] lim
  );
    logic signed [PROD_W-1:0] lim_w;
    lim_w = PROD_W'(lim);
    if (v > lim_w) begin
      return lim;
    end else if (v < -lim_w) begin
      return -lim;
    end
    return ANGLE_W'(v);
  endfunction

  function automatic logic signed [ANGLE_W-1:0] rad_angle(input logic signed [ACC_W-1:0] a);
    logic signed [ACC_W:0] ra;
    logic signed [ACC_W:0] rq;
    ra = {a[ACC_W-1], a};
    ra = ra + RAD_BIAS;
    rq = ra >>> RAD_SHIFT;
    return sat_angle(PROD_W'(rq), RAD_LIMIT);
  endfunction

  function automatic logic signed [ANGLE_W-1:0] deg_angle(
    input logic signed [PH_W-1:0] ph,
    input logic signed [PL_W-1:0] pl
  );
    logic signed [PROD_W-1:0] sum;
    logic signed [PROD_W-1:0] q;
    sum = (PROD_W'(ph) <<< FRAC_SHIFT) + PROD_W'(pl) + DEG_BIAS;
    q = sum >>> DEG_SHIFT;
    return sat_angle(q, DEG_LIMIT);
  endfunction

  logic                          st_valid;
  fmt_stage_t                    st;
  fmt_stage_t                    st_next;
  logic                          hold_a;
  logic                          hold_b;
  logic                          res_valid;
  c2s_result_t                   res;
  c2s_result_t                   res_next;
  logic signed [HI_W-1:0]        az_hi;
  logic signed [HI_W-1:0]        el_hi;
  logic signed [FRAC_SHIFT:0]    az_lo;
  logic signed [FRAC_SHIFT:0]    el_lo;
  logic                          round_up;
  logic [SQ_PAIRS:0]             rnd;

  assign hold_b = res_valid & down_hold;
  assign hold_a = st_valid & hold_b;
  assign hold   = hold_a;

  // first cell: radian result and degree partial products, range rounding
  always_comb begin
    az_hi = in_data.az_acc[ACC_W-1:FRAC_SHIFT];
    el_hi = in_data.el_acc[ACC_W-1:FRAC_SHIFT];
    az_lo = {1'b0, in_data.az_acc[FRAC_SHIFT-1:0]};
    el_lo = {1'b0, in_data.el_acc[FRAC_SHIFT-1:0]};
    st_next.az_ok = in_data.az_ok;
    st_next.el_ok = in_data.el_ok;
    st_next.az_rad = rad_angle(in_data.az_acc);
    st_next.el_rad = rad_angle(in_data.el_acc);
    st_next.az_ph = az_hi * DEG_PER_RAD_Q24;
    st_next.az_pl = az_lo * DEG_PER_RAD_Q24;
    st_next.el_ph = el_hi * DEG_PER_RAD_Q24;
    st_next.el_pl = el_lo * DEG_PER_RAD_Q24;
    // round to nearest: remainder above root means past the half point
    round_up = (in_data.sq_rem > SQ_REM_W'(in_data.sq_root));
    rnd = (SQ_PAIRS+1)'(in_data.sq_root) + (SQ_PAIRS+1)'(round_up);
    st_next.range = (rnd > (SQ_PAIRS+1)'(RANGE_MAX)) ? RANGE_MAX : rnd[RANGE_W-1:0];
  end

  // second cell: combine partials and pick the unit
  always_comb begin
    res_next.azimuth_valid = st.az_ok;
    res_next.elevation_valid = st.el_ok;
    res_next.range = st.range;
    if (!st.az_ok) begin
      res_next.azimuth = '0;
    end else if (angle_in_degrees) begin
      res_next.azimuth = deg_angle(st.az_ph, st.az_pl);
    end else begin
      res_next.azimuth = st.az_rad;
    end
    if (!st.el_ok) begin
      res_next.elevation = '0;
    end else if (angle_in_degrees) begin
      res_next.elevation = deg_angle(st.el_ph, st.el_pl);
    end else begin
      res_next.elevation = st.el_rad;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (!hold_a) begin
        st_valid <= in_valid;
      end
      if (!hold_b) begin
        res_valid <= st_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!hold_a && in_valid) begin
      st <= st_next;
    end
    if (!hold_b && st_valid) begin
      res <= res_next;
    end
  end

  assign out_valid  = res_valid;
  assign out_result = res;

endmodule

@@ rtl/cartesian_to_spherical.sv @@
// Top level of the cartesian to spherical converter.
// Depends on c2s_pkg, c2s_prep, c2s_cell, c2s_format and the assertion macros.
//
// Usage
//   point channel: point (x, y, z signed), point_valid, point_stall. A beat is
//   taken on a rising edge with point_valid high and point_stall low.
//   result channel: result (azimuth, elevation, range and two flags),
//   result_valid, result_stall; a beat leaves on valid high and stall low.
//   cfg channel: cfg_valid, cfg_ready (always high), cfg_data selects degrees
//   (1, Q10.6) or radians (0, Q3.13). Write it only while no beat is in flight.
//   A beat passes the entry cell, the chain of CELLS cells, where
//   CELLS = max(2 * stages, COORD_WIDTH + 1), and the output cells. One beat
//   per cycle is sustained while result_stall is low: each cell of the chain
//   holds one point and does at most one CORDIC rotation and one root digit.
//   Stalls: every cell holds only while it is full and the cell after it
//   holds, so bubbles close up and new beats still enter while the result
//   register waits; point_stall rises once the whole chain is full and
//   result_stall is high. Reset: rst empties the chain and selects radians; no clearing pass.
`include "cartesian_to_spherical_defines.svh"
module cartesian_to_spherical import c2s_pkg::*; #(
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        point_valid,
  output logic        point_stall,
  input  c2s_point_t  point,
  output logic        result_valid,
  input  logic        result_stall,
  output c2s_result_t result,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data
);

  // stages past the table length add nothing
  localparam int STAGES_RUN = (CORDIC_STAGES > TABLE_LEN) ? TABLE_LEN : CORDIC_STAGES;
  localparam int CELLS = (2 * STAGES_RUN > SQ_PAIRS) ? 2 * STAGES_RUN : SQ_PAIRS;

  logic            angle_in_degrees;
  logic [CELLS:0]  vld;
  logic [CELLS+1:0] hld;
  c2s_cell_t       dat [CELLS+1];

  // config register: one bit, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      angle_in_degrees <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      angle_in_degrees <= cfg_data;
    end
  end

  // entry cell: scaling, quarter turn, sum of squares
  c2s_prep u_prep (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (point_valid),
    .in_point  (point),
    .down_hold (hld[1]),
    .hold      (hld[0]),
    .out_valid (vld[0]),
    .out_data  (dat[0])
  );

  assign point_stall = hld[0];

  // chain: azimuth rotations, then elevation rotations, root digits alongside
  for (genvar k = 1; k <= CELLS; k++) begin : g_cell
    c2s_cell #(
      .IDX        (k - 1),
      .STAGES_RUN (STAGES_RUN)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (vld[k-1]),
      .in_data   (dat[k-1]),
      .down_hold (hld[k+1]),
      .hold      (hld[k]),
      .out_valid (vld[k]),
      .out_data  (dat[k])
    );
  end

  // scale angles, round range, drive the result register
  c2s_format u_format (
    .clk              (clk),
    .rst              (rst),
    .angle_in_degrees (angle_in_degrees),
    .in_valid         (vld[CELLS]),
    .in_data          (dat[CELLS]),
    .down_hold        (result_stall),
    .hold             (hld[CELLS+1]),
    .out_valid        (result_valid),
    .out_result       (result)
  );

  // a flagged angle is forced to zero
  `CS_ASSERT_NOW(a_az_zero, result_valid && !result.azimuth_valid, result.azimuth == '0)
  // a zero point has no azimuth either, and zero length
  `CS_ASSERT_NOW(a_el_zero, result_valid && !result.elevation_valid,
                 !result.azimuth_valid && result.elevation == '0 && result.range == '0)
  // degree mode stays within a half turn
  `CS_ASSERT_NOW(a_deg_limit, result_valid && angle_in_degrees,
                 result.azimuth <= DEG_LIMIT && result.azimuth >= -DEG_LIMIT &&
                 result.elevation <= DEG_LIMIT && result.elevation >= -DEG_LIMIT)
  // input backs up only behind a full chain and a waiting result
  `CS_ASSERT_NOW(a_stall_full, point_stall, result_valid && result_stall)
  `CS_ASSERT_NOW(a_free_flow, !result_stall, !point_stall)
  `CS_ASSERT_NEXT(a_stall_keeps, point_stall, result_valid)

endmodule
